/* hw/rtl/lcdw_pkg.sv */
// Shared types, codes and constants for the character LCD write sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lcdw_pkg;

    localparam int CFG_DELAY_W = 24;
    localparam int ROW_BASE_W  = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 8;

    localparam logic [CFG_DELAY_W-1:0] STROBE_RESET  = 24'd100000;
    localparam logic [CFG_DELAY_W-1:0] POWERUP_RESET = 24'd750000;
    localparam logic [ROW_BASE_W-1:0]  ROW0_RESET    = 7'd0;
    localparam logic [ROW_BASE_W-1:0]  ROW1_RESET    = 7'd64;
    localparam logic [ROW_BASE_W-1:0]  ROW2_RESET    = 7'd20;
    localparam logic [ROW_BASE_W-1:0]  ROW3_RESET    = 7'd84;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STROBE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POWERUP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3    = 3'd5;

    // Init sequence steps
    localparam logic [3:0] INIT_NONE  = 4'd0;
    localparam logic [3:0] INIT_WAIT  = 4'd1;
    localparam logic [3:0] INIT_FIRST = 4'd2;
    localparam logic [3:0] INIT_LAST_NIBBLE = 4'd4;
    localparam logic [3:0] INIT_LAST_CHAIN  = 4'd7;

    localparam logic [7:0] LCD_WAKE     = 8'h30;
    localparam logic [7:0] LCD_4BIT     = 8'h20;
    localparam logic [7:0] LCD_FUNC_SET = 8'h28;
    localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
    localparam logic [7:0] LCD_ENTRY    = 8'h06;
    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_DATA   = 3'd1,
        CMD_INSTR  = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_INIT   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        PH_HI_EN = 2'd0,
        PH_HI_LO = 2'd1,
        PH_LO_EN = 2'd2,
        PH_LO_LO = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] held_byte;
        logic       held_rs;
        logic [3:0] init_step;
        logic       busy;
        logic [3:0] nibble;
        logic       en;
    } t_seq_st;

    typedef struct packed {
        logic       accepted;
        logic       busy_res;
        logic       lcd_en;
        logic       lcd_rs;
        logic [3:0] lcd_data;
    } t_lcd_res;

    typedef struct packed {
        logic [CFG_DELAY_W-1:0]     strobe;
        logic [CFG_DELAY_W-1:0]     powerup;
        logic [3:0][ROW_BASE_W-1:0] row_base;
    } t_cfg;

    function automatic logic [7:0] init_item(input logic [3:0] step);
        logic [7:0] b;
        case (step)
            4'd2, 4'd3: b = LCD_WAKE;
            4'd4:       b = LCD_4BIT;
            4'd5:       b = LCD_FUNC_SET;
            4'd6:       b = LCD_DISP_ON;
            4'd7:       b = LCD_ENTRY;
            4'd8:       b = LCD_CLEAR;
            default:    b = '0;
        endcase
        return b;
    endfunction

    // Begin a byte: high nibble out, enable raised
    function automatic t_seq_st start_st(input t_seq_st s, input logic [7:0] b,
                                         input logic rs);
        t_seq_st o;
        o           = s;
        o.held_byte = b;
        o.held_rs   = rs;
        o.phase     = PH_HI_EN;
        o.nibble    = b[7:4];
        o.en        = 1'b1;
        o.busy      = 1'b1;
        return o;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/char_lcd_4bit_write_sequencer.sv */
// Top level: 4-bit character LCD write sequencer, one input beat per tick.
//
//  channel   dir  handshake               payload
//  s (in)    in   i_s_tvalid/o_s_tready   i_s_tuser: cmd; i_s_tdata: byte_value, column, row
//  m (out)   out  o_m_tvalid/i_m_tready   o_m_tuser: rs; o_m_tdata: lcd_data, en, busy, accepted
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Each input beat produces one result beat, captured in the result register.
// A new beat is taken every cycle while the result register is empty or draining.
// Strobe and power-up timing count input beats, not clock cycles.
// Reset restores the default delays and row bases and stops any transfer.
// A stall on the master side holds the result and blocks the slave side.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_4bit_write_sequencer
    import lcdw_pkg::*;
#(
    parameter int DELAY_WIDTH = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output      logic                   o_s_tready,
    // [7:0] byte_value, [14:8] column, [16:15] row, [23:17] zero
    input  wire logic [S_TDATA_W-1:0]   i_s_tdata,
    // [2:0] cmd
    input  wire logic [S_TUSER_W-1:0]   i_s_tuser,
    output      logic                   o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [3:0] lcd_data, [4] lcd_en, [5] busy_res, [6] accepted, [7] zero
    output      logic [M_TDATA_W-1:0]   o_m_tdata,
    // [0] lcd_rs
    output      logic                   o_m_tuser,
    input  wire logic                   i_cfg_valid,
    output      logic                   o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DELAY_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_lcd_res res;
    logic     space;
    logic     take;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = space;
    assign take        = i_s_tvalid && space;

    lcdw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lcdw_core #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_cmd        (i_s_tuser),
        .i_byte_value (i_s_tdata[7:0]),
        .i_column     (i_s_tdata[14:8]),
        .i_row        (i_s_tdata[16:15]),
        .i_cfg        (cfg),
        .o_res        (res)
    );

    lcdw_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_res      (res),
        .o_space    (space),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* hw/rtl/lcdw_cfg.sv */
// Configuration register file: strobe and power-up delays, row base addresses.
`timescale 1ns / 1ps
`default_nettype none

module lcdw_cfg
    import lcdw_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DELAY_W-1:0] i_cfg_data,
    output      t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STROBE:  n_cfg.strobe      = i_cfg_data;
                REG_POWERUP: n_cfg.powerup     = i_cfg_data;
                REG_ROW0:    n_cfg.row_base[0] = i_cfg_data[ROW_BASE_W-1:0];
                REG_ROW1:    n_cfg.row_base[1] = i_cfg_data[ROW_BASE_W-1:0];
                REG_ROW2:    n_cfg.row_base[2] = i_cfg_data[ROW_BASE_W-1:0];
                REG_ROW3:    n_cfg.row_base[3] = i_cfg_data[ROW_BASE_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strobe      <= STROBE_RESET;
            r_cfg.powerup     <= POWERUP_RESET;
            r_cfg.row_base[0] <= ROW0_RESET;
            r_cfg.row_base[1] <= ROW1_RESET;
            r_cfg.row_base[2] <= ROW2_RESET;
            r_cfg.row_base[3] <= ROW3_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/lcdw_core.sv */
// Sequencer state and the per-beat next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module lcdw_core
    import lcdw_pkg::*;
#(
    parameter int DELAY_WIDTH = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic [2:0]            i_cmd,
    input  wire logic [7:0]            i_byte_value,
    input  wire logic [ROW_BASE_W-1:0] i_column,
    input  wire logic [1:0]            i_row,
    input  wire t_cfg                  i_cfg,
    output      t_lcd_res              o_res
);

    localparam int WIDE_W = (DELAY_WIDTH > CFG_DELAY_W) ? DELAY_WIDTH : CFG_DELAY_W;
    localparam logic [WIDE_W-1:0] DELAY_MAX = WIDE_W'({DELAY_WIDTH{1'b1}});

    t_seq_st                r_st;
    t_seq_st                n_st;
    logic [DELAY_WIDTH-1:0] r_dcnt;
    logic [DELAY_WIDTH-1:0] n_dcnt;

    logic [WIDE_W-1:0]      strobe_wide;
    logic [WIDE_W-1:0]      powerup_wide;
    logic [DELAY_WIDTH-1:0] strobe_sat;
    logic [DELAY_WIDTH-1:0] powerup_sat;
    logic [DELAY_WIDTH-1:0] strobe_load;
    logic [DELAY_WIDTH-1:0] powerup_load;
    logic                   item_done;
    logic                   accepted;
    logic [ROW_BASE_W-1:0]  cursor_addr;

    // Phase lengths: saturate to the counter, zero counts as one tick
    always_comb begin
        strobe_wide  = WIDE_W'(i_cfg.strobe);
        powerup_wide = WIDE_W'(i_cfg.powerup);
        strobe_sat   = (strobe_wide > DELAY_MAX) ? {DELAY_WIDTH{1'b1}}
                                                 : strobe_wide[DELAY_WIDTH-1:0];
        powerup_sat  = (powerup_wide > DELAY_MAX) ? {DELAY_WIDTH{1'b1}}
                                                  : powerup_wide[DELAY_WIDTH-1:0];
        strobe_load  = (strobe_sat == '0) ? '0 : strobe_sat - 1'b1;
        powerup_load = (powerup_sat == '0) ? '0 : powerup_sat - 1'b1;
    end

    assign cursor_addr = i_cfg.row_base[i_row] + i_column;

    // Next state: advance the running sequence, then take a request if idle
    always_comb begin
        n_st      = r_st;
        n_dcnt    = r_dcnt;
        item_done = 1'b0;
        accepted  = 1'b0;

        if (r_st.busy) begin
            if (r_dcnt != '0) begin
                n_dcnt = r_dcnt - 1'b1;
            end else if (r_st.init_step == INIT_WAIT) begin
                n_st           = start_st(r_st, init_item(INIT_FIRST), 1'b0);
                n_st.init_step = INIT_FIRST;
                n_dcnt         = strobe_load;
            end else begin
                unique case (r_st.phase)
                    PH_HI_EN: begin
                        n_st.phase = PH_HI_LO;
                        n_st.en    = 1'b0;
                        n_dcnt     = strobe_load;
                    end
                    PH_HI_LO: begin
                        // Raw wake-up nibbles carry no low half
                        if (r_st.init_step >= INIT_FIRST &&
                            r_st.init_step <= INIT_LAST_NIBBLE) begin
                            item_done = 1'b1;
                        end else begin
                            n_st.phase  = PH_LO_EN;
                            n_st.nibble = r_st.held_byte[3:0];
                            n_st.en     = 1'b1;
                            n_dcnt      = strobe_load;
                        end
                    end
                    PH_LO_EN: begin
                        n_st.phase = PH_LO_LO;
                        n_st.en    = 1'b0;
                        n_dcnt     = strobe_load;
                    end
                    PH_LO_LO: begin
                        item_done = 1'b1;
                    end
                    default: begin
                        item_done = 1'b1;
                    end
                endcase

                if (item_done) begin
                    if (r_st.init_step >= INIT_FIRST && r_st.init_step <= INIT_LAST_CHAIN) begin
                        n_st = start_st(r_st, init_item(r_st.init_step + 4'd1), 1'b0);
                        n_st.init_step = r_st.init_step + 4'd1;
                        n_dcnt = strobe_load;
                    end else begin
                        n_st.init_step = INIT_NONE;
                        n_st.busy      = 1'b0;
                        n_st.en        = 1'b0;
                        n_st.held_rs   = 1'b0;
                        n_st.phase     = PH_HI_EN;
                    end
                end
            end
        end

        if (!n_st.busy) begin
            unique case (t_cmd'(i_cmd))
                CMD_DATA: begin
                    n_st     = start_st(n_st, i_byte_value, 1'b1);
                    n_dcnt   = strobe_load;
                    accepted = 1'b1;
                end
                CMD_INSTR: begin
                    n_st     = start_st(n_st, i_byte_value, 1'b0);
                    n_dcnt   = strobe_load;
                    accepted = 1'b1;
                end
                CMD_CURSOR: begin
                    n_st     = start_st(n_st, LCD_SET_DDRAM | {1'b0, cursor_addr}, 1'b0);
                    n_dcnt   = strobe_load;
                    accepted = 1'b1;
                end
                CMD_INIT: begin
                    n_st.init_step = INIT_WAIT;
                    n_st.phase     = PH_HI_EN;
                    n_st.held_byte = '0;
                    n_st.held_rs   = 1'b0;
                    n_st.nibble    = '0;
                    n_st.en        = 1'b0;
                    n_st.busy      = 1'b1;
                    n_dcnt         = powerup_load;
                    accepted       = 1'b1;
                end
                default: begin
                    accepted = 1'b0;
                end
            endcase
        end
    end

    // Pins after this beat
    always_comb begin
        o_res.lcd_data = n_st.nibble;
        o_res.lcd_rs   = n_st.busy & n_st.held_rs;
        o_res.lcd_en   = n_st.en;
        o_res.busy_res = n_st.busy;
        o_res.accepted = accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase     <= PH_HI_EN;
            r_st.held_byte <= '0;
            r_st.held_rs   <= 1'b0;
            r_st.init_step <= INIT_NONE;
            r_st.busy      <= 1'b0;
            r_st.nibble    <= '0;
            r_st.en        <= 1'b0;
            r_dcnt         <= '0;
        end else if (i_take) begin
            r_st   <= n_st;
            r_dcnt <= n_dcnt;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lcdw_out.sv */
// Result register toward the master side; refills in the cycle it drains.
`timescale 1ns / 1ps
`default_nettype none

module lcdw_out
    import lcdw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire t_lcd_res             i_res,
    output      logic                 o_space,
    output      logic                 o_m_tvalid,
    input  wire logic                 i_m_tready,
    output      logic [M_TDATA_W-1:0] o_m_tdata,
    output      logic                 o_m_tuser
);

    logic     r_valid;
    t_lcd_res r_res;

    assign o_space = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load && o_space) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_res.accepted, r_res.busy_res, r_res.lcd_en, r_res.lcd_data};
    assign o_m_tuser  = r_res.lcd_rs;

endmodule

`default_nettype wire

/* tb/lcd_pin_checker.sv */
// Checker for the LCD write sequencer: predicts every result beat and compares it.
`timescale 1ns / 1ps

module lcd_pin_checker
    import lcdw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    input  logic [S_TUSER_W-1:0]   i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [M_TDATA_W-1:0]   i_m_tdata,
    input  logic                   i_m_tuser,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DELAY_W-1:0] i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output logic                   o_busy
);

    // Power-up bytes in send order, first one in the lowest slot
    localparam logic [6:0][7:0] BOOT_BYTES = {LCD_CLEAR, LCD_ENTRY, LCD_DISP_ON, LCD_FUNC_SET,
                                              LCD_4BIT, LCD_WAKE, LCD_WAKE};

    t_cfg                   cfg;
    t_phase                 ph;
    logic [CFG_DELAY_W-1:0] dly;
    logic [7:0]             held;
    logic                   held_rs;
    logic [3:0]             init_st;
    logic                   busy;
    logic [3:0]             nib;
    logic                   en;

    t_lcd_res pin_queue[$];
    int       fails;

    function automatic logic [CFG_DELAY_W-1:0] phase_count(input logic [CFG_DELAY_W-1:0] ticks);
        return (ticks == '0) ? '0 : ticks - 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    task automatic load_byte(input logic [7:0] b, input logic rs);
        held    = b;
        held_rs = rs;
        ph      = PH_HI_EN;
        nib     = b[7:4];
        en      = 1'b1;
        dly     = phase_count(cfg.strobe);
        busy    = 1'b1;
    endtask

    task automatic byte_done;
        if (init_st >= INIT_FIRST && init_st <= INIT_LAST_CHAIN) begin
            init_st = init_st + 1'b1;
            load_byte(BOOT_BYTES[init_st - INIT_FIRST], 1'b0);
        end else begin
            init_st = INIT_NONE;
            busy    = 1'b0;
            en      = 1'b0;
            held_rs = 1'b0;
            ph      = PH_HI_EN;
        end
    endtask

    task automatic next_phase;
        if (init_st == INIT_WAIT) begin
            init_st = INIT_FIRST;
            load_byte(BOOT_BYTES[0], 1'b0);
        end else begin
            case (ph)
                PH_HI_EN: begin
                    ph  = PH_HI_LO;
                    en  = 1'b0;
                    dly = phase_count(cfg.strobe);
                end
                PH_HI_LO: begin
                    // the raw wake-up nibbles stop after the high half
                    if (init_st >= INIT_FIRST && init_st <= INIT_LAST_NIBBLE) begin
                        byte_done();
                    end else begin
                        ph  = PH_LO_EN;
                        nib = held[3:0];
                        en  = 1'b1;
                        dly = phase_count(cfg.strobe);
                    end
                end
                PH_LO_EN: begin
                    ph  = PH_LO_LO;
                    en  = 1'b0;
                    dly = phase_count(cfg.strobe);
                end
                default: byte_done();
            endcase
        end
    endtask

    task automatic predict_pins(input logic [S_TUSER_W-1:0] cmd,
                                input logic [S_TDATA_W-1:0] beat, output t_lcd_res pins);
        logic [7:0] b;
        logic [6:0] col;
        logic [6:0] addr;
        logic [1:0] row;
        logic       took;
        b    = beat[7:0];
        col  = beat[14:8];
        row  = beat[16:15];
        took = 1'b0;
        // a running transfer moves first, then an idle block may take the request
        if (busy) begin
            if (dly != '0)
                dly = dly - 1'b1;
            else
                next_phase();
        end
        if (!busy) begin
            case (cmd)
                CMD_DATA: begin
                    load_byte(b, 1'b1);
                    took = 1'b1;
                end
                CMD_INSTR: begin
                    load_byte(b, 1'b0);
                    took = 1'b1;
                end
                CMD_CURSOR: begin
                    addr = cfg.row_base[row] + col;
                    load_byte(LCD_SET_DDRAM | {1'b0, addr}, 1'b0);
                    took = 1'b1;
                end
                CMD_INIT: begin
                    init_st = INIT_WAIT;
                    ph      = PH_HI_EN;
                    held    = '0;
                    held_rs = 1'b0;
                    nib     = '0;
                    en      = 1'b0;
                    dly     = phase_count(cfg.powerup);
                    busy    = 1'b1;
                    took    = 1'b1;
                end
                default: ;
            endcase
        end
        pins.lcd_data = nib;
        pins.lcd_rs   = busy & held_rs;
        pins.lcd_en   = en;
        pins.busy_res = busy;
        pins.accepted = took;
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DELAY_W-1:0] value);
        case (idx)
            REG_STROBE:  cfg.strobe      = value;
            REG_POWERUP: cfg.powerup     = value;
            REG_ROW0:    cfg.row_base[0] = value[ROW_BASE_W-1:0];
            REG_ROW1:    cfg.row_base[1] = value[ROW_BASE_W-1:0];
            REG_ROW2:    cfg.row_base[2] = value[ROW_BASE_W-1:0];
            REG_ROW3:    cfg.row_base[3] = value[ROW_BASE_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_lcd_res got;
        t_lcd_res want;
        t_lcd_res pins;
        if (!i_rst_n) begin
            cfg.strobe      = STROBE_RESET;
            cfg.powerup     = POWERUP_RESET;
            cfg.row_base[0] = ROW0_RESET;
            cfg.row_base[1] = ROW1_RESET;
            cfg.row_base[2] = ROW2_RESET;
            cfg.row_base[3] = ROW3_RESET;
            ph      = PH_HI_EN;
            dly     = '0;
            held    = '0;
            held_rs = 1'b0;
            init_st = INIT_NONE;
            busy    = 1'b0;
            nib     = '0;
            en      = 1'b0;
            fails   = 0;
            pin_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                write_cfg(i_cfg_index, i_cfg_data);
            // check the outgoing beat before queueing this edge's prediction
            if (i_m_tvalid && i_m_tready) begin
                got.lcd_data = i_m_tdata[3:0];
                got.lcd_rs   = i_m_tuser;
                got.lcd_en   = i_m_tdata[4];
                got.busy_res = i_m_tdata[5];
                got.accepted = i_m_tdata[6];
                if (pin_queue.size() == 0) begin
                    report_mismatch("result beat with nothing pending", got, 0);
                end else begin
                    want = pin_queue.pop_front();
                    check_field("lcd_data", got.lcd_data, want.lcd_data);
                    check_field("lcd_rs", got.lcd_rs, want.lcd_rs);
                    check_field("lcd_en", got.lcd_en, want.lcd_en);
                    check_field("busy_res", got.busy_res, want.busy_res);
                    check_field("accepted", got.accepted, want.accepted);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_pins(i_s_tuser, i_s_tdata, pins);
                pin_queue.push_back(pins);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pin_queue.size();
        o_busy       <= busy;
    end

endmodule

/* tb/testbench.sv */
// Testbench top for the LCD write sequencer: stimulus, config phases and verdict.
`timescale 1ns / 1ps

module testbench;
    import lcdw_pkg::*;

    localparam int                     CYCLE_LIMIT     = 1_000_000;
    localparam int                     RANDOM_BEATS    = 90;
    localparam logic [2:0]             CMD_SPARE_LO    = 3'd5;
    localparam logic [2:0]             CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0]             CMD_SPARE_HI    = 3'd7;
    localparam logic [7:0]             RETURN_HOME     = 8'h02;
    localparam logic [CFG_DELAY_W-1:0] DELAY_TOP       = '1;
    localparam logic [CFG_DELAY_W-1:0] ROW_TOP         = 24'd127;

    typedef struct packed {
        logic [S_TUSER_W-1:0] cmd;
        logic [S_TDATA_W-1:0] data;
    } t_req;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;
    logic [S_TUSER_W-1:0]   i_s_tuser   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DELAY_W-1:0] i_cfg_data  = '0;

    int   tx_gap_pct   = 0;
    int   rx_stall_pct = 0;
    int   cycles       = 0;
    int   fail_count;
    int   pending;
    logic seq_busy;

    char_lcd_4bit_write_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lcd_pin_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_busy       (seq_busy)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[char_lcd_4bit_write_sequencer] ERROR");
            $finish;
        end
    end

    function automatic t_req pack_beat(input logic [2:0] cmd, input logic [7:0] b,
                                       input logic [6:0] col, input logic [1:0] row);
        t_req r;
        r.cmd  = cmd;
        r.data = {7'b0, row, col, b};
        return r;
    endfunction

    // Mostly requests and plain ticks, a few unused codes
    function automatic t_req random_beat;
        int         r;
        logic [2:0] cmd;
        r = $urandom_range(99);
        if (r < 45)
            cmd = CMD_TICK;
        else if (r < 67)
            cmd = CMD_DATA;
        else if (r < 80)
            cmd = CMD_INSTR;
        else if (r < 93)
            cmd = CMD_CURSOR;
        else if (r < 96)
            cmd = CMD_INIT;
        else
            cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        return pack_beat(cmd, 8'($urandom), 7'($urandom), 2'($urandom));
    endfunction

    task automatic send_beat(input t_req beat);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= beat.cmd;
        i_s_tdata  <= beat.data;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
    endtask

    task automatic wait_quiet;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Feed ticks until the running transfer or init has finished
    task automatic drain_idle;
        wait_quiet();
        while (seq_busy) begin
            send_beat(pack_beat(CMD_TICK, '0, '0, '0));
            wait_quiet();
        end
    endtask

    task automatic request(input t_req beat);
        drain_idle();
        send_beat(beat);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DELAY_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic program_regs(input logic [CFG_DELAY_W-1:0] strobe,
                                input logic [CFG_DELAY_W-1:0] powerup,
                                input logic [CFG_DELAY_W-1:0] r0, input logic [CFG_DELAY_W-1:0] r1,
                                input logic [CFG_DELAY_W-1:0] r2, input logic [CFG_DELAY_W-1:0] r3);
        drain_idle();
        repeat (4) @(posedge i_clk);
        write_reg(REG_STROBE, strobe);
        write_reg(REG_POWERUP, powerup);
        write_reg(REG_ROW0, r0);
        write_reg(REG_ROW1, r1);
        write_reg(REG_ROW2, r2);
        write_reg(REG_ROW3, r3);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_beats(input int n);
        repeat (n)
            send_beat(random_beat());
    endtask

    task automatic noise_beats(input int n);
        logic [2:0] cmd;
        repeat (n) begin
            cmd = ($urandom_range(3) == 0) ? CMD_TICK : 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            send_beat(pack_beat(cmd, 8'($urandom), 7'($urandom), 2'($urandom)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        tx_gap_pct   = 9;
        rx_stall_pct = 84;

        // short strobe, row bases left at their reset values
        write_reg(REG_STROBE, 24'd1);
        write_reg(REG_POWERUP, 24'd2);
        i_cfg_valid <= 1'b0;

        request(pack_beat(CMD_DATA, 8'h00, '0, '0));
        request(pack_beat(CMD_DATA, 8'hFF, '0, '0));
        request(pack_beat(CMD_DATA, 8'h5A, '0, '0));
        request(pack_beat(CMD_INSTR, LCD_CLEAR, '0, '0));
        request(pack_beat(CMD_INSTR, RETURN_HOME, '0, '0));
        request(pack_beat(CMD_INSTR, 8'hFF, '0, '0));
        request(pack_beat(CMD_INSTR, 8'h00, '0, '0));
        request(pack_beat(CMD_CURSOR, '0, 7'd0, 2'd0));
        request(pack_beat(CMD_CURSOR, '0, 7'd0, 2'd1));
        request(pack_beat(CMD_CURSOR, '0, 7'd127, 2'd2));
        request(pack_beat(CMD_CURSOR, '0, 7'd127, 2'd3));
        // row base plus column wraps past the top of display memory
        request(pack_beat(CMD_CURSOR, '0, 7'd44, 2'd3));
        request(pack_beat(CMD_INIT, '0, '0, '0));
        request(pack_beat(CMD_TICK, 8'hFF, 7'd127, 2'd3));
        request(pack_beat(CMD_SPARE_LO, 8'hFF, 7'd127, 2'd3));
        request(pack_beat(CMD_SPARE_MID, 8'h00, 7'd0, 2'd0));
        request(pack_beat(CMD_SPARE_HI, 8'hAA, 7'd85, 2'd2));
        // requests while busy must be dropped
        request(pack_beat(CMD_DATA, 8'h41, '0, '0));
        send_beat(pack_beat(CMD_DATA, 8'h42, '0, '0));
        send_beat(pack_beat(CMD_INIT, '0, '0, '0));
        request(pack_beat(CMD_INIT, '0, '0, '0));
        send_beat(pack_beat(CMD_INSTR, LCD_SET_DDRAM, '0, '0));
        send_beat(pack_beat(CMD_CURSOR, '0, 7'd5, 2'd1));

        // zero strobe acts as one tick, extreme row bases
        program_regs('0, 24'd1, ROW_TOP, '0, ROW_TOP, '0);
        random_beats(RANDOM_BEATS);

        tx_gap_pct   = 84;
        rx_stall_pct = 9;
        // upper data bits on the row registers must be masked off
        program_regs(24'd3, 24'd5, CFG_DELAY_W'($urandom), CFG_DELAY_W'($urandom),
                     CFG_DELAY_W'($urandom), CFG_DELAY_W'($urandom));
        random_beats(RANDOM_BEATS);

        // longest delays: only ticks and unused codes, nothing starts
        program_regs(DELAY_TOP, DELAY_TOP, '0, ROW_TOP, '0, ROW_TOP);
        noise_beats(30);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        program_regs(24'd2, '0, CFG_DELAY_W'($urandom_range(127)),
                     CFG_DELAY_W'($urandom_range(127)), CFG_DELAY_W'($urandom_range(127)),
                     CFG_DELAY_W'($urandom_range(127)));
        random_beats(RANDOM_BEATS);

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[char_lcd_4bit_write_sequencer] OK");
        end else begin
            $display("[char_lcd_4bit_write_sequencer] ERROR");
        end
        $finish;
    end

endmodule
